// ===== design/smi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types, constants and fixed-point helpers of the small matrix
// inverse block.
// ----------------------------------------------------------------------------
package smi_pkg;

   localparam int MaxDim     = 4;
   localparam int DimW       = $clog2(MaxDim);
   localparam int DimCntW    = $clog2(MaxDim + 1);
   localparam int StoreDepth = MaxDim * MaxDim;
   localparam int AddrW      = $clog2(StoreDepth);
   localparam int CountW     = $clog2(StoreDepth + 1);
   localparam int QW         = 32;
   localparam int FracW      = 16;
   localparam int DivW       = QW + FracW;
   localparam int DivCntW    = $clog2(DivW);
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 16;

   typedef logic signed [QW-1:0] q_type;
   typedef logic [1:0]           status_type;
   typedef logic [1:0]           mode_type;

   localparam status_type StatusOk        = 2'd0;
   localparam status_type StatusBadMatrix = 2'd1;
   localparam status_type StatusCalcErr   = 2'd2;

   localparam mode_type ModeDet   = 2'd0;
   localparam mode_type ModeCof   = 2'd1;
   localparam mode_type ModeInv   = 2'd2;
   localparam mode_type ModeTrans = 2'd3;

   localparam logic [CsrIdxW-1:0] RegOpMode   = 2'd0;
   localparam logic [CsrIdxW-1:0] RegRowCount = 2'd1;
   localparam logic [CsrIdxW-1:0] RegColCount = 2'd2;
   localparam logic [CsrIdxW-1:0] RegSingLim  = 2'd3;

   localparam q_type QMax = 32'sh7FFF_FFFF;
   localparam q_type QMin = 32'sh8000_0000;

   // Clamps a wide signed value to the Q16.16 range.
   function automatic q_type sat_q(input logic signed [65:0] v);
      q_type r;
      if (v > 66'sd2147483647) begin
         r = QMax;
      end else if (v < -66'sd2147483648) begin
         r = QMin;
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/smi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_req_if / smi_rsp_if
// Valid/ready channels carrying matrix elements in and result items out.
// ----------------------------------------------------------------------------
interface smi_req_if;
   logic          valid;
   logic          ready;
   smi_pkg::q_type element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

interface smi_rsp_if;
   logic                valid;
   logic                ready;
   smi_pkg::q_type      value;
   smi_pkg::status_type status;
   logic                is_last;

   modport source (output valid, output value, output status, output is_last, input ready);
   modport sink   (input valid, input value, input status, input is_last, output ready);
endinterface

// ===== design/small_matrix_inverse_adjugate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_inverse_adjugate
// Determinant, cofactor matrix, inverse and transpose of a matrix of up to
// 4x4 signed Q16.16 elements, computed by a small sequencer around one
// shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while the output register is free. Once
// the last element of the matrix has arrived the block drops ready and works
// through the result on its own: the cofactor recursion runs as an explicit
// stack, each product term passing the shared 33x32 multiplier and
// accumulator. Every inverse element additionally passes a restoring divider
// that produces one quotient bit per cycle. A transpose reads each item
// straight from the store. Result items are held in an output register;
// ready returns once the last item of the burst has been handed over to
// that register and that register is free.
// ----------------------------------------------------------------------------
module small_matrix_inverse_adjugate (
   input  logic                          clock,
   input  logic                          reset,
   smi_req_if.sink                       req_ch,
   smi_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [smi_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [smi_pkg::CsrDataW-1:0]  csr_data
);

   localparam int DimW    = smi_pkg::DimW;
   localparam int DimCntW = smi_pkg::DimCntW;
   localparam int MaxDim  = smi_pkg::MaxDim;
   localparam int QW      = smi_pkg::QW;
   localparam int DivW    = smi_pkg::DivW;

   typedef enum logic [11:0] {
      S_LOAD   = 12'b0000_0000_0001,
      S_START  = 12'b0000_0000_0010,
      S_ECALL  = 12'b0000_0000_0100,
      S_ESCAN  = 12'b0000_0000_1000,
      S_ERET   = 12'b0000_0001_0000,
      S_EMUL   = 12'b0000_0010_0000,
      S_EACC   = 12'b0000_0100_0000,
      S_POST   = 12'b0000_1000_0000,
      S_CHECK  = 12'b0001_0000_0000,
      S_DIV    = 12'b0010_0000_0000,
      S_DIVFIN = 12'b0100_0000_0000,
      S_EMIT   = 12'b1000_0000_0000
   } state_type;

   // Configuration
   smi_pkg::mode_type        op_mode_ff;
   logic [DimCntW-1:0]       row_count_ff;
   logic [DimCntW-1:0]       col_count_ff;
   logic [15:0]              sing_limit_ff;

   // Control
   state_type                state_ff, state_in;
   logic [smi_pkg::CountW-1:0] load_count_ff, load_count_in;
   logic [DimW-1:0]          oi_ff, oi_in, oj_ff, oj_in;
   logic                     det_phase_ff, det_phase_in;
   logic                     out_valid_ff, out_valid_in;
   smi_pkg::q_type           det_ff, det_in;

   // Datapath
   smi_pkg::q_type           store_ff [smi_pkg::StoreDepth];
   logic [DimW-1:0]          lvl_ff, lvl_in;
   logic [DimCntW-1:0]       top_size_ff, top_size_in;
   logic [DimCntW-1:0]       skip_ff, skip_in;
   smi_pkg::q_type           ret_ff, ret_in;
   logic signed [64:0]       prod_ff, prod_in;
   smi_pkg::q_type           pend_value_ff, pend_value_in;
   smi_pkg::status_type      pend_status_ff, pend_status_in;
   logic                     pend_last_ff, pend_last_in;
   smi_pkg::q_type           out_value_ff, out_value_in;
   smi_pkg::status_type      out_status_ff, out_status_in;
   logic                     out_last_ff, out_last_in;
   logic [QW-1:0]            dsr_ff, dsr_in;
   logic [QW-1:0]            rem_ff, rem_in;
   logic [DivW-1:0]          dq_ff, dq_in;
   logic [smi_pkg::DivCntW-1:0] dcnt_ff, dcnt_in;
   logic                     neg_ff, neg_in;

   // One frame of the cofactor recursion per level
   logic [MaxDim-1:0]        mask_ff [MaxDim];
   logic [DimW:0]            cur_ff  [MaxDim];
   logic                     par_ff  [MaxDim];
   smi_pkg::q_type           acc_ff  [MaxDim];
   logic signed [QW:0]       a_ff    [MaxDim];

   // Combinational helpers
   logic                     req_accept, out_free, bad_size, store_we, eng_start;
   logic [smi_pkg::CountW-1:0] total, load_base, next_count;
   logic [DimW-1:0]          rd_row, rd_col, eng_row, lone_col, cur_idx, lvl_up;
   logic [4:0]               rd_lin;
   smi_pkg::q_type           rd_data, prod_q, acc_sum, cof, div_res;
   logic [MaxDim-1:0]        full_mask, eng_mask0, mask_cur, col_bit;
   logic [DimW:0]            cur_cur;
   logic                     scan_done, scan_hit, base_case, last_item, singular;
   logic [DimCntW-1:0]       olim, ilim;
   logic signed [QW:0]       scan_a, cmag;
   logic [QW-1:0]            det_abs;
   logic [QW:0]              rem_sh;
   logic                     div_ge;
   logic [DimW-1:0]          cof_row, cof_col;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_LOAD) && out_free;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.value   = out_value_ff;
   assign rsp_ch.status  = out_status_ff;
   assign rsp_ch.is_last = out_last_ff;

   assign bad_size = (row_count_ff == '0) || (col_count_ff == '0)
                  || (row_count_ff > DimCntW'(MaxDim)) || (col_count_ff > DimCntW'(MaxDim));
   assign total      = smi_pkg::CountW'(row_count_ff) * smi_pkg::CountW'(col_count_ff);
   assign load_base  = (load_count_ff >= total) ? '0 : load_count_ff;
   assign next_count = load_base + smi_pkg::CountW'(1);

   // Frame of the current recursion level
   assign mask_cur  = mask_ff[lvl_ff];
   assign cur_cur   = cur_ff[lvl_ff];
   assign cur_idx   = cur_cur[DimW-1:0];
   assign scan_done = (cur_cur == (DimW+1)'(MaxDim));
   assign scan_hit  = mask_cur[cur_idx];
   assign col_bit   = MaxDim'(1) << cur_idx;
   assign lvl_up    = lvl_ff + DimW'(1);
   assign base_case = ((top_size_ff - DimCntW'(lvl_ff)) == DimCntW'(1));
   assign eng_row   = (DimCntW'(lvl_ff) >= skip_ff) ? lvl_ff + DimW'(1) : lvl_ff;

   always_comb begin
      lone_col = '0;
      for (int k = 0; k < MaxDim; k++) begin
         if (mask_cur[k]) lone_col = DimW'(k);
      end
   end

   always_comb begin
      for (int k = 0; k < MaxDim; k++) begin
         full_mask[k] = (k < int'(row_count_ff));
      end
   end

   // Element read port of the matrix store
   always_comb begin
      if (state_ff == S_START) begin
         rd_row = oj_ff;
         rd_col = oi_ff;
      end else if (state_ff == S_ECALL) begin
         rd_row = eng_row;
         rd_col = lone_col;
      end else begin
         rd_row = eng_row;
         rd_col = cur_idx;
      end
   end
   assign rd_lin  = 5'(rd_row) * 5'(col_count_ff) + 5'(rd_col);
   assign rd_data = store_ff[rd_lin[smi_pkg::AddrW-1:0]];

   assign scan_a  = par_ff[lvl_ff] ? -(33'(rd_data)) : 33'(rd_data);
   assign prod_q  = smi_pkg::sat_q(66'(prod_ff >>> smi_pkg::FracW));
   assign acc_sum = smi_pkg::sat_q(66'(acc_ff[lvl_ff]) + 66'(prod_q));

   // A cofactor at an odd position is negated, with -(-2^31) clamped
   assign cof = (oi_ff[0] ^ oj_ff[0]) ? smi_pkg::sat_q(-(66'(ret_ff))) : ret_ff;
   assign cmag = cof[QW-1] ? -(33'(cof)) : 33'(cof);
   assign det_abs = det_ff[QW-1] ? QW'(-(33'(det_ff))) : QW'(det_ff);
   assign singular = (det_ff == '0) || (det_abs < QW'(sing_limit_ff));

   assign cof_row = (op_mode_ff == smi_pkg::ModeCof) ? oi_ff : oj_ff;
   assign cof_col = (op_mode_ff == smi_pkg::ModeCof) ? oj_ff : oi_ff;

   assign olim = (op_mode_ff == smi_pkg::ModeTrans) ? col_count_ff : row_count_ff;
   assign ilim = (op_mode_ff == smi_pkg::ModeTrans) ? row_count_ff : col_count_ff;
   assign last_item = (DimCntW'(oi_ff) == olim - DimCntW'(1))
                   && (DimCntW'(oj_ff) == ilim - DimCntW'(1));

   assign rem_sh = {rem_ff, dq_ff[DivW-1]};
   assign div_ge = (rem_sh >= {1'b0, dsr_ff});

   always_comb begin
      if (neg_ff) begin
         if (dq_ff > DivW'(64'h8000_0000)) div_res = smi_pkg::QMin;
         else div_res = QW'(-(dq_ff));
      end else begin
         if (dq_ff > DivW'(64'h7FFF_FFFF)) div_res = smi_pkg::QMax;
         else div_res = dq_ff[QW-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      load_count_in  = load_count_ff;
      oi_in          = oi_ff;
      oj_in          = oj_ff;
      det_phase_in   = det_phase_ff;
      det_in         = det_ff;
      out_valid_in   = out_valid_ff && !rsp_ch.ready;
      out_value_in   = out_value_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      lvl_in         = lvl_ff;
      top_size_in    = top_size_ff;
      skip_in        = skip_ff;
      ret_in         = ret_ff;
      prod_in        = prod_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      dsr_in         = dsr_ff;
      rem_in         = rem_ff;
      dq_in          = dq_ff;
      dcnt_in        = dcnt_ff;
      neg_in         = neg_ff;
      store_we       = 1'b0;
      eng_start      = 1'b0;
      eng_mask0      = full_mask;

      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (bad_size) begin
                  load_count_in = '0;
                  out_valid_in  = 1'b1;
                  out_value_in  = '0;
                  out_status_in = smi_pkg::StatusBadMatrix;
                  out_last_in   = 1'b1;
               end else begin
                  store_we = 1'b1;
                  if (next_count == total) begin
                     load_count_in = '0;
                     oi_in         = '0;
                     oj_in         = '0;
                     det_phase_in  = (op_mode_ff == smi_pkg::ModeDet)
                                  || (op_mode_ff == smi_pkg::ModeInv);
                     state_in      = S_START;
                  end else begin
                     load_count_in = next_count;
                  end
               end
            end
         end
         S_START: begin
            if (op_mode_ff == smi_pkg::ModeTrans) begin
               pend_value_in  = rd_data;
               pend_status_in = smi_pkg::StatusOk;
               pend_last_in   = last_item;
               state_in       = S_EMIT;
            end else if (row_count_ff != col_count_ff) begin
               pend_value_in  = '0;
               pend_status_in = smi_pkg::StatusCalcErr;
               pend_last_in   = 1'b1;
               state_in       = S_EMIT;
            end else if (det_phase_ff) begin
               eng_start   = 1'b1;
               skip_in     = DimCntW'(MaxDim);
               top_size_in = row_count_ff;
               lvl_in      = '0;
               state_in    = S_ECALL;
            end else if (row_count_ff == DimCntW'(1)) begin
               // The cofactor of a single element is the element itself.
               ret_in   = rd_data;
               state_in = S_POST;
            end else begin
               eng_start   = 1'b1;
               eng_mask0   = full_mask & ~(MaxDim'(1) << cof_col);
               skip_in     = DimCntW'(cof_row);
               top_size_in = row_count_ff - DimCntW'(1);
               lvl_in      = '0;
               state_in    = S_ECALL;
            end
         end
         S_ECALL: begin
            if (base_case) begin
               ret_in   = rd_data;
               state_in = S_ERET;
            end else begin
               state_in = S_ESCAN;
            end
         end
         S_ESCAN: begin
            if (scan_done) begin
               ret_in   = acc_ff[lvl_ff];
               state_in = S_ERET;
            end else if (scan_hit) begin
               lvl_in   = lvl_up;
               state_in = S_ECALL;
            end
         end
         S_ERET: begin
            if (lvl_ff == '0) begin
               state_in = S_POST;
            end else begin
               lvl_in   = lvl_ff - DimW'(1);
               state_in = S_EMUL;
            end
         end
         S_EMUL: begin
            prod_in  = 65'(a_ff[lvl_ff]) * 65'(ret_ff);
            state_in = S_EACC;
         end
         S_EACC: begin
            state_in = S_ESCAN;
         end
         S_POST: begin
            if (det_phase_ff) begin
               det_in = ret_ff;
               if (op_mode_ff == smi_pkg::ModeDet) begin
                  pend_value_in  = ret_ff;
                  pend_status_in = smi_pkg::StatusOk;
                  pend_last_in   = 1'b1;
                  state_in       = S_EMIT;
               end else begin
                  det_phase_in = 1'b0;
                  state_in     = S_CHECK;
               end
            end else if (op_mode_ff == smi_pkg::ModeCof) begin
               pend_value_in  = cof;
               pend_status_in = smi_pkg::StatusOk;
               pend_last_in   = last_item;
               state_in       = S_EMIT;
            end else begin
               dq_in    = {cmag[QW-1:0], {smi_pkg::FracW{1'b0}}};
               dsr_in   = det_abs;
               rem_in   = '0;
               dcnt_in  = '0;
               neg_in   = cof[QW-1] ^ det_ff[QW-1];
               state_in = S_DIV;
            end
         end
         S_CHECK: begin
            if (singular) begin
               pend_value_in  = '0;
               pend_status_in = smi_pkg::StatusCalcErr;
               pend_last_in   = 1'b1;
               state_in       = S_EMIT;
            end else begin
               state_in = S_START;
            end
         end
         S_DIV: begin
            rem_in  = div_ge ? QW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[QW-1:0];
            dq_in   = {dq_ff[DivW-2:0], div_ge};
            dcnt_in = dcnt_ff + smi_pkg::DivCntW'(1);
            if (dcnt_ff == smi_pkg::DivCntW'(DivW - 1)) state_in = S_DIVFIN;
         end
         S_DIVFIN: begin
            pend_value_in  = div_res;
            pend_status_in = smi_pkg::StatusOk;
            pend_last_in   = last_item;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_value_in  = pend_value_ff;
               out_status_in = pend_status_ff;
               out_last_in   = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  if (DimCntW'(oj_ff) == ilim - DimCntW'(1)) begin
                     oj_in = '0;
                     oi_in = oi_ff + DimW'(1);
                  end else begin
                     oj_in = oj_ff + DimW'(1);
                  end
                  state_in = S_START;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff    <= smi_pkg::ModeDet;
         row_count_ff  <= DimCntW'(1);
         col_count_ff  <= DimCntW'(1);
         sing_limit_ff <= 16'd1;
         state_ff      <= S_LOAD;
         load_count_ff <= '0;
         oi_ff         <= '0;
         oj_ff         <= '0;
         det_phase_ff  <= 1'b0;
         det_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               smi_pkg::RegOpMode:   op_mode_ff    <= csr_data[1:0];
               smi_pkg::RegRowCount: row_count_ff  <= csr_data[DimCntW-1:0];
               smi_pkg::RegColCount: col_count_ff  <= csr_data[DimCntW-1:0];
               smi_pkg::RegSingLim:  sing_limit_ff <= csr_data[15:0];
            endcase
         end
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         oi_ff         <= oi_in;
         oj_ff         <= oj_in;
         det_phase_ff  <= det_phase_in;
         det_ff        <= det_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff         <= lvl_in;
      top_size_ff    <= top_size_in;
      skip_ff        <= skip_in;
      ret_ff         <= ret_in;
      prod_ff        <= prod_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      out_value_ff   <= out_value_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
      dsr_ff         <= dsr_in;
      rem_ff         <= rem_in;
      dq_ff          <= dq_in;
      dcnt_ff        <= dcnt_in;
      neg_ff         <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) store_ff[load_base[smi_pkg::AddrW-1:0]] <= req_ch.element;
   end

   // Recursion frames: a call opens the next level with the chosen column
   // removed, and each returned minor is weighted and accumulated.
   always_ff @(posedge clock) begin
      if ((state_ff == S_START) && eng_start) mask_ff[0] <= eng_mask0;
      if ((state_ff == S_ECALL) && !base_case) begin
         acc_ff[lvl_ff] <= '0;
         cur_ff[lvl_ff] <= '0;
         par_ff[lvl_ff] <= 1'b0;
      end
      if ((state_ff == S_ESCAN) && !scan_done) begin
         if (scan_hit) begin
            a_ff[lvl_ff]    <= scan_a;
            mask_ff[lvl_up] <= mask_cur & ~col_bit;
         end else begin
            cur_ff[lvl_ff] <= cur_cur + (DimW+1)'(1);
         end
      end
      if (state_ff == S_EACC) begin
         acc_ff[lvl_ff] <= acc_sum;
         cur_ff[lvl_ff] <= cur_cur + (DimW+1)'(1);
         par_ff[lvl_ff] <= !par_ff[lvl_ff];
      end
   end

   a_bad_size_reply: assert property (@(posedge clock) disable iff (reset)
      (req_accept && bad_size) |=>
         (rsp_ch.valid && rsp_ch.status == smi_pkg::StatusBadMatrix && rsp_ch.is_last))
      else $error("bad matrix size did not produce an error item");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ECALL) |-> (DimCntW'(lvl_ff) < top_size_ff))
      else $error("recursion level beyond the minor size");

   a_load_count_range: assert property (@(posedge clock) disable iff (reset)
      load_count_ff < smi_pkg::CountW'(smi_pkg::StoreDepth))
      else $error("load count beyond the store depth");

endmodule

// ===== verif/tb_small_matrix_inverse_adjugate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_small_matrix_inverse_adjugate
// Self-checking bench for the small matrix determinant, cofactor, inverse
// and transpose block. Matrices are streamed in element by element under
// a range of sizes, modes and singularity limits, while both handshakes
// idle at random. A fixed-point predictor inside the bench works out each
// burst of result items, and every result item is compared with it.
// ----------------------------------------------------------------------------
module tb_small_matrix_inverse_adjugate;

   localparam int WatchdogLimit = 20000;
   localparam int LongHold      = 400;
   localparam int LoadSettle    = 3000;

   typedef struct {
      smi_pkg::q_type      value;
      smi_pkg::status_type status;
      logic                is_last;
   } result_item_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [smi_pkg::CsrIdxW-1:0]  csr_index;
   logic [smi_pkg::CsrDataW-1:0] csr_data;

   smi_req_if req_bus ();
   smi_rsp_if rsp_bus ();

   small_matrix_inverse_adjugate u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Predictor state and its copy of the registers.
   smi_pkg::mode_type cfg_mode;
   int       cfg_rows;
   int       cfg_cols;
   int       cfg_limit;
   smi_pkg::q_type mat_store [smi_pkg::StoreDepth];
   int       fill_count;
   smi_pkg::q_type last_det;

   smi_pkg::q_type  pending_elems [$];
   result_item_type expected_results [$];

   int  send_idle;
   int  recv_idle;
   bit  hold_req;
   int  hold_left;
   bit  req_fire;
   bit  rsp_fire;
   int  quiet_cycles;
   int  errors;
   int  mismatches;
   int  elems_sent;
   int  elems_taken;
   int  results_seen;
   int  setups_done;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic smi_pkg::q_type clamp_q(input longint v);
      if (v > 64'sd2147483647) begin
         return smi_pkg::QMax;
      end
      if (v < -64'sd2147483648) begin
         return smi_pkg::QMin;
      end
      return smi_pkg::q_type'(v);
   endfunction

   // The arithmetic shift floors the product, as the block does.
   function automatic smi_pkg::q_type mul_q(input longint a, input longint b);
      longint p;
      p = a * b;
      return clamp_q(p >>> 16);
   endfunction

   function automatic void take_minor(input smi_pkg::q_type m [smi_pkg::StoreDepth],
                                      input int n, input int r, input int c,
                                      output smi_pkg::q_type sub [smi_pkg::StoreDepth]);
      int k;
      k = 0;
      for (int i = 0; i < smi_pkg::StoreDepth; i++) begin
         sub[i] = '0;
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (i != r && j != c) begin
               sub[k] = m[i * n + j];
               k++;
            end
         end
      end
   endfunction

   function automatic smi_pkg::q_type det_n(input smi_pkg::q_type m [smi_pkg::StoreDepth],
                                            input int n);
      smi_pkg::q_type sub [smi_pkg::StoreDepth];
      smi_pkg::q_type acc;
      longint a;
      acc = '0;
      if (n <= 1) begin
         return m[0];
      end
      for (int c = 0; c < n; c++) begin
         a = longint'(m[c]);
         if (c % 2 == 1) begin
            a = -a;
         end
         take_minor(m, n, 0, c, sub);
         acc = clamp_q(longint'(acc) + longint'(mul_q(a, longint'(det_n(sub, n - 1)))));
      end
      return acc;
   endfunction

   function automatic smi_pkg::q_type cofactor_n(
         input smi_pkg::q_type m [smi_pkg::StoreDepth], input int n,
         input int r, input int c);
      smi_pkg::q_type sub [smi_pkg::StoreDepth];
      smi_pkg::q_type d;
      if (n <= 1) begin
         return m[0];
      end
      take_minor(m, n, r, c, sub);
      d = det_n(sub, n - 1);
      if ((r + c) % 2 == 1) begin
         return clamp_q(-longint'(d));
      end
      return d;
   endfunction

   function automatic void expect_item(input smi_pkg::q_type v,
                                       input smi_pkg::status_type st,
                                       input logic last);
      result_item_type it;
      it.value   = v;
      it.status  = st;
      it.is_last = last;
      expected_results.push_back(it);
   endfunction

   // Works out the result items caused by one accepted element.
   function automatic void predict_element(input smi_pkg::q_type e);
      int     total;
      int     n;
      longint d;
      longint ad;
      if (cfg_rows == 0 || cfg_cols == 0 || cfg_rows > smi_pkg::MaxDim
          || cfg_cols > smi_pkg::MaxDim) begin
         fill_count = 0;
         expect_item('0, smi_pkg::StatusBadMatrix, 1'b1);
         return;
      end
      total = cfg_rows * cfg_cols;
      if (fill_count >= total) begin
         fill_count = 0;
      end
      mat_store[fill_count % smi_pkg::StoreDepth] = e;
      fill_count++;
      if (fill_count < total) begin
         return;
      end
      fill_count = 0;
      if (cfg_mode == smi_pkg::ModeTrans) begin
         for (int i = 0; i < cfg_cols; i++) begin
            for (int j = 0; j < cfg_rows; j++) begin
               expect_item(mat_store[j * cfg_cols + i], smi_pkg::StatusOk,
                           (i == cfg_cols - 1) && (j == cfg_rows - 1));
            end
         end
         return;
      end
      if (cfg_rows != cfg_cols) begin
         expect_item('0, smi_pkg::StatusCalcErr, 1'b1);
         return;
      end
      n = cfg_rows;
      if (cfg_mode == smi_pkg::ModeDet) begin
         last_det = det_n(mat_store, n);
         expect_item(last_det, smi_pkg::StatusOk, 1'b1);
         return;
      end
      if (cfg_mode == smi_pkg::ModeCof) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               expect_item(cofactor_n(mat_store, n, i, j), smi_pkg::StatusOk,
                           (i == n - 1) && (j == n - 1));
            end
         end
         return;
      end
      last_det = det_n(mat_store, n);
      d  = longint'(last_det);
      ad = (d < 0) ? -d : d;
      if (d == 0 || ad < longint'(cfg_limit)) begin
         expect_item('0, smi_pkg::StatusCalcErr, 1'b1);
         return;
      end
      // The inverse is the adjugate over the determinant, so the cofactor indices are swapped.
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            expect_item(clamp_q((longint'(cofactor_n(mat_store, n, j, i)) * 65536) / d),
                        smi_pkg::StatusOk, (i == n - 1) && (j == n - 1));
         end
      end
   endfunction

   // Handshakes are sampled at the rising edge; drivers move on the falling one.
   always @(posedge clock) begin
      result_item_type want;
      req_fire = !reset && req_bus.valid && req_bus.ready;
      rsp_fire = !reset && rsp_bus.valid && rsp_bus.ready;
      if (req_fire) begin
         elems_taken++;
         predict_element(req_bus.element);
      end
      if (rsp_fire) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result item: value %h status %0d last %b",
                        rsp_bus.value, rsp_bus.status, rsp_bus.is_last);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.value !== want.value || rsp_bus.status !== want.status ||
                rsp_bus.is_last !== want.is_last) begin
               errors++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Result mismatch: expected value %h status %0d last %b,",
                           want.value, want.status, want.is_last);
                  $display("   got value %h status %0d last %b",
                           rsp_bus.value, rsp_bus.status, rsp_bus.is_last);
               end
            end
         end
      end
      if (reset || req_fire || rsp_fire) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Timed out with %0d result items outstanding", expected_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Element driver.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.element <= '0;
      end else if (!req_bus.valid || req_fire) begin
         if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_bus.valid   <= 1'b1;
            req_bus.element <= pending_elems.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver, with an occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic write_reg(input logic [smi_pkg::CsrIdxW-1:0] idx, input int data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data[smi_pkg::CsrDataW-1:0];
      case (idx)
         smi_pkg::RegOpMode:   cfg_mode  = smi_pkg::mode_type'(data[1:0]);
         smi_pkg::RegRowCount: cfg_rows  = data & 7;
         smi_pkg::RegColCount: cfg_cols  = data & 7;
         smi_pkg::RegSingLim:  cfg_limit = data & 16'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic setup(input smi_pkg::mode_type mode, input int rows, input int cols,
                        input int limit);
      write_reg(smi_pkg::RegOpMode, int'(mode));
      write_reg(smi_pkg::RegRowCount, rows);
      write_reg(smi_pkg::RegColCount, cols);
      write_reg(smi_pkg::RegSingLim, limit);
      setups_done++;
   endtask

   task automatic push_elem(input smi_pkg::q_type e);
      pending_elems.push_back(e);
      elems_sent++;
   endtask

   // Waits until everything sent has been taken and answered.
   task automatic drain(input int extra);
      while (pending_elems.size() > 0 || req_bus.valid || expected_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (extra) @(negedge clock);
   endtask

   // Mostly values of a few units so that products stay in range; some raw.
   function automatic smi_pkg::q_type pick_elem();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) begin
         return smi_pkg::q_type'($urandom());
      end
      if (sel == 1) begin
         return ($urandom_range(1) == 0) ? smi_pkg::QMax : smi_pkg::QMin;
      end
      return smi_pkg::q_type'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
   endfunction

   task automatic queue_matrices(input int count, input int size);
      for (int i = 0; i < count * size; i++) begin
         push_elem(pick_elem());
      end
   endtask

   initial begin
      smi_pkg::mode_type mode;
      int  rows;
      int  cols;
      int  mats;
      bit  pressed;
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cfg_mode   = smi_pkg::ModeDet;
      cfg_rows   = 1;
      cfg_cols   = 1;
      cfg_limit  = 1;
      fill_count = 0;
      last_det   = '0;
      for (int i = 0; i < smi_pkg::StoreDepth; i++) begin
         mat_store[i] = '0;
      end
      send_idle = 38;
      recv_idle = 71;
      hold_req  = 1'b0;
      pressed   = 1'b0;
      errors = 0;
      mismatches = 0;
      elems_sent = 0;
      elems_taken = 0;
      results_seen = 0;
      setups_done = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset configuration: a 1x1 determinant of both extremes.
      push_elem(smi_pkg::QMax);
      push_elem(smi_pkg::QMin);
      drain(5);
      // A 1x1 cofactor matrix copies its element.
      setup(smi_pkg::ModeCof, 1, 1, 1);
      push_elem(smi_pkg::QMin);
      drain(5);
      // Saturating 2x2 determinant.
      setup(smi_pkg::ModeDet, 2, 2, 1);
      push_elem(smi_pkg::QMax); push_elem(smi_pkg::QMin);
      push_elem(smi_pkg::QMin); push_elem(smi_pkg::QMax);
      drain(5);
      // Zero determinant with a zero limit still fails.
      setup(smi_pkg::ModeInv, 2, 2, 0);
      repeat (4) push_elem('0);
      drain(5);
      // Determinant below the largest limit.
      setup(smi_pkg::ModeInv, 2, 2, 65535);
      push_elem(32'sd1); push_elem('0); push_elem('0); push_elem(32'sd1);
      drain(5);
      // Single-row transpose and a non-square cofactor request.
      setup(smi_pkg::ModeTrans, 1, 3, 1);
      push_elem(32'sh0001_0000); push_elem(-32'sh0002_8000); push_elem(32'sh7FFF_0000);
      drain(5);
      setup(smi_pkg::ModeCof, 1, 2, 1);
      push_elem(32'sh0003_0000); push_elem(32'sh0000_0001);
      drain(5);
      // Zero and oversized dimensions.
      setup(smi_pkg::ModeDet, 0, 4, 1);
      push_elem(32'sh1234_5678);
      drain(5);
      setup(smi_pkg::ModeInv, 7, 7, 1);
      push_elem(smi_pkg::QMin);
      drain(5);
      // Shrinking the size part way through a load restarts it.
      setup(smi_pkg::ModeDet, 2, 2, 1);
      push_elem(32'sh0001_0000); push_elem(32'sh0002_0000); push_elem(32'sh0003_0000);
      drain(LoadSettle);
      setup(smi_pkg::ModeDet, 1, 2, 1);
      push_elem(32'sh0004_0000); push_elem(32'sh0005_0000);
      drain(5);

      while (elems_sent < 470) begin
         if (elems_sent > 360) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (elems_sent > 200) begin
            send_idle = 71;
            recv_idle = 38;
         end
         if (!pressed && elems_sent > 280) begin
            // Hold results back while full matrices keep arriving.
            pressed = 1'b1;
            setup(smi_pkg::ModeTrans, 4, 4, 1);
            hold_req = 1'b1;
            queue_matrices(3, 16);
            drain(5);
         end else if ($urandom_range(9) == 0) begin
            setup(smi_pkg::mode_type'($urandom_range(3)),
                  5 * $urandom_range(1) + $urandom_range(2),
                  $urandom_range(7), $urandom_range(65535));
            if (cfg_rows != 0 && cfg_cols != 0 && cfg_rows <= smi_pkg::MaxDim
                && cfg_cols <= smi_pkg::MaxDim) begin
               write_reg(smi_pkg::RegRowCount, 0);
            end
            queue_matrices(3, 1);
            drain(5);
         end else begin
            mode = smi_pkg::mode_type'($urandom_range(3));
            rows = $urandom_range(4, 1);
            cols = (mode != smi_pkg::ModeTrans && $urandom_range(4) != 0)
                   ? rows : $urandom_range(4, 1);
            mats = (rows * cols > 9) ? $urandom_range(2, 1) : $urandom_range(5, 2);
            setup(mode, rows, cols,
                  ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(16));
            queue_matrices(mats, rows * cols);
            drain(5);
         end
      end

      drain(50);
      if (expected_results.size() > 0) begin
         errors++;
      end
      $display("Streamed %0d elements under %0d register setups and checked %0d result items.",
               elems_taken, setups_done, results_seen);
      $display("Mismatches: %0d.", mismatches);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
